// File: sv/rgbhsl_pkg.sv
// Shared constants and the hue sector type for the RGB to HSL converter.
package rgbhsl_pkg;

    localparam int CHANNEL_BITS_DEF = 8;
    localparam int HUE_W = 9;
    localparam int PCT_W = 7;
    localparam int N_DIV = 2;       // divider lanes per cell: hue, saturation

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

endpackage

// File: sv/rgbhsl_if.sv
// Valid/ready stream interface carrying one transaction payload.
interface rgbhsl_if #(
    parameter int W = 8
) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/rgbhsl_div_cell.sv
// One restoring-division cell: one quotient bit per stage, for the hue and saturation lanes.
module rgbhsl_div_cell
    import rgbhsl_pkg::*;
#(
    parameter int NW = 20,
    parameter int DW = 14,
    parameter int QW = 9,
    parameter int SHIFT = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_den   [N_DIV],
    input  logic [NW-1:0] i_rem   [N_DIV],
    input  logic [QW-1:0] i_quo   [N_DIV],
    output logic [DW-1:0] o_den   [N_DIV],
    output logic [NW-1:0] o_rem   [N_DIV],
    output logic [QW-1:0] o_quo   [N_DIV]
);
    logic [NW+DW-1:0] w_trial [N_DIV];
    logic             w_ge    [N_DIV];

    always_comb begin
        for (int k = 0; k < N_DIV; k++) begin
            w_trial[k] = {{DW{1'b0}}, i_rem[k]};
            w_ge[k] = w_trial[k] >= ({{NW{1'b0}}, i_den[k]} << SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N_DIV; k++) begin
                o_den[k] <= i_den[k];
                o_rem[k] <= w_ge[k]
                    ? NW'(w_trial[k] - ({{NW{1'b0}}, i_den[k]} << SHIFT)) : i_rem[k];
                o_quo[k] <= {i_quo[k][QW-2:0], w_ge[k]};
            end
        end
    end
endmodule

// File: sv/rgb_to_hsl_converter.sv
// Top level: RGB pixel to integer HSL, pipelined as a chain of divider cells.
//
// Usage: pixels enter on the s_in channel (red, green, blue, CHANNEL_BITS each)
// and HSL results leave on m_out (hue 9 bits, saturation 7, lightness 7).
// A transaction moves when valid and ready are both high.
// Stage 0 registers the hue and saturation numerators and divisors, plus a
// reciprocal estimate of lightness (division by full scale). A row of QW
// restoring-division cells, alike but for the shift of the divisor, then
// produces one quotient bit each per cycle while the chain advances, for hue
// and saturation side by side; the first cell's cycle also corrects the
// lightness estimate by one. The last cell's registers hold the result; the
// hue sign is fixed combinationally on the way out.
// Throughput: one pixel per clock while the output is not stalled; the whole chain advances as one unit.
// Stall: when the receiver holds ready low with a result waiting, the
// chain freezes and input ready drops; nothing is lost or repeated.
// Reset clears all valid bits; payload registers are not reset.
// Hue division is done on |numerator| with the sign applied at the end,
// which truncates toward zero like the arithmetic it replaces.
module rgb_to_hsl_converter
    import rgbhsl_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rgbhsl_if.sink   s_in,
    rgbhsl_if.source m_out
);
    localparam int CB = CHANNEL_BITS;
    localparam int NW = CB + 9;     // numerators up to 100*FS or 300*d
    localparam int DW = CB + 1;
    localparam int QW = 9;          // quotients below 512
    localparam int NS = QW + 1;

    logic [CB-1:0] w_r, w_g, w_b, w_mx, w_mn;
    assign w_r = s_in.data[3*CB-1:2*CB];
    assign w_g = s_in.data[2*CB-1:CB];
    assign w_b = s_in.data[CB-1:0];

    logic [DW-1:0] w_sum, w_d, w_full;
    logic          w_light_lo, w_neg;
    t_sector       w_sec;
    logic [NW-1:0] w_hnum;
    logic signed [NW:0] w_hsig;
    logic [NW-1:0] w_lnum;
    logic [NW:0]   w_lacc;
    logic [PCT_W-1:0] w_lest;

    always_comb begin
        w_mx = w_r; w_mn = w_r;
        if (w_g > w_mx) w_mx = w_g;
        if (w_b > w_mx) w_mx = w_b;
        if (w_g < w_mn) w_mn = w_g;
        if (w_b < w_mn) w_mn = w_b;
        w_full = DW'((1 << CB) - 1);
        w_sum  = DW'(w_mx) + DW'(w_mn);
        w_d    = DW'(w_mx) - DW'(w_mn);
        // 50*sum < 50*FS  <=> sum < FS
        w_light_lo = w_sum < w_full;
        // x/(2^CB-1) ~ (x + x>>CB + x>>2CB) >> CB; never high, at most one low
        w_lnum = NW'(w_sum) * NW'(50);
        w_lacc = (NW+1)'(w_lnum) + (NW+1)'(w_lnum >> CB) + (NW+1)'(w_lnum >> (2 * CB));
        w_lest = PCT_W'(w_lacc >> CB);
        if (w_b == w_mx)      w_sec = SEC_BLUE;
        else if (w_g == w_mx) w_sec = SEC_GREEN;
        else                  w_sec = SEC_RED;
        case (w_sec)
            SEC_BLUE:  w_hsig = (NW+1)'(240) * $signed({1'b0, w_d})
                              + (NW+1)'(60) * ($signed({1'b0, w_r}) - $signed({1'b0, w_g}));
            SEC_GREEN: w_hsig = (NW+1)'(120) * $signed({1'b0, w_d})
                              + (NW+1)'(60) * ($signed({1'b0, w_b}) - $signed({1'b0, w_r}));
            default:   w_hsig = (NW+1)'(60) * ($signed({1'b0, w_g}) - $signed({1'b0, w_b}));
        endcase
        w_neg  = w_hsig[NW];
        w_hnum = w_neg ? NW'(-w_hsig) : NW'(w_hsig);
    end

    logic w_adv;
    logic r_v [NS];
    logic r_gray [NS], r_nneg [NS];
    logic [DW-1:0] r_den0 [N_DIV];
    logic [NW-1:0] r_rem0 [N_DIV];
    logic [NW-1:0] r_lnum0;
    logic [PCT_W-1:0] r_light [NS];
    logic [DW-1:0] r_den [NS][N_DIV];
    logic [NW-1:0] r_rem [NS][N_DIV];
    logic [QW-1:0] r_quo [NS][N_DIV];
    logic [NW-1:0] w_lrem;
    logic          w_lfix;

    assign w_adv = !r_v[NS-1] || m_out.ready;
    assign s_in.ready = w_adv;

    // lightness estimate fix-up: bump by one when the remainder reaches full scale
    always_comb begin
        w_lrem = r_lnum0 - ((NW'(r_light[0]) << CB) - NW'(r_light[0]));
        w_lfix = w_lrem >= NW'((1 << CB) - 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) r_v[s] <= 1'b0;
        end else if (w_adv) begin
            r_v[0] <= s_in.valid;
            for (int s = 1; s < NS; s++) r_v[s] <= r_v[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_gray[0] <= w_d == '0;
            r_nneg[0] <= w_neg;
            r_den0[0] <= (w_d == '0) ? DW'(1) : w_d;
            r_den0[1] <= (w_d == '0) ? DW'(1)
                       : (w_light_lo ? w_sum : DW'(2 * ((1 << CB) - 1)) - w_sum);
            r_rem0[0] <= w_hnum;
            r_rem0[1] <= NW'(w_d) * NW'(100);
            r_lnum0    <= w_lnum;
            r_light[0] <= w_lest;
            r_light[1] <= r_light[0] + PCT_W'(w_lfix);
            for (int s = 1; s < NS; s++) begin
                r_gray[s] <= r_gray[s-1];
                r_nneg[s] <= r_nneg[s-1];
            end
            for (int s = 2; s < NS; s++) r_light[s] <= r_light[s-1];
        end
    end

    assign r_den[0] = r_den0;
    assign r_rem[0] = r_rem0;
    for (genvar k = 0; k < N_DIV; k++) begin : g_quo0
        assign r_quo[0][k] = '0;
    end

    for (genvar s = 1; s < NS; s++) begin : g_cell
        rgbhsl_div_cell #(.NW(NW), .DW(DW), .QW(QW), .SHIFT(QW - s)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_den (r_den[s-1]),
            .i_rem (r_rem[s-1]),
            .i_quo (r_quo[s-1]),
            .o_den (r_den[s]),
            .o_rem (r_rem[s]),
            .o_quo (r_quo[s])
        );
    end

    logic [QW-1:0] w_hue;
    always_comb begin
        w_hue = r_quo[NS-1][0];
        if (r_gray[NS-1]) w_hue = '0;
        else if (r_nneg[NS-1] && w_hue != '0) w_hue = QW'(360) - w_hue;
    end

    assign m_out.valid = r_v[NS-1];
    assign m_out.data  = {HUE_W'(w_hue),
                          r_gray[NS-1] ? PCT_W'(0) : PCT_W'(r_quo[NS-1][1]),
                          r_light[NS-1]};
endmodule

// File: test/tb_rgb_to_hsl_converter.sv
// Testbench for the RGB to HSL converter: random and directed pixels, checked against a predictor.
`timescale 1ns / 1ps

module tb_rgb_to_hsl_converter;
    import rgbhsl_pkg::*;

    localparam int CB = CHANNEL_BITS_DEF;
    localparam int IN_W = 3 * CB;
    localparam int OUT_W = HUE_W + 2 * PCT_W;
    localparam int FS = (1 << CB) - 1;
    localparam int N_RANDOM = 400;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [CB-1:0] red;
        logic [CB-1:0] green;
        logic [CB-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] saturation;
        logic [PCT_W-1:0] lightness;
    } t_hsl;

    logic i_clk;
    logic i_rst_n;

    rgbhsl_if #(.W(IN_W))  pix_if ();
    rgbhsl_if #(.W(OUT_W)) hsl_if ();

    rgb_to_hsl_converter #(.CHANNEL_BITS(CB)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .s_in   (pix_if.sink),
        .m_out  (hsl_if.source)
    );

    t_pixel pending_pixels[$];
    t_hsl   expected_hsl[$];
    int     mismatches = 0;
    int     checked = 0;
    int     idle_cycles = 0;
    int     send_gap = 0;
    int     recv_gap = 0;
    bit     feed_done = 0;

    // Exact integer HSL; division truncates toward zero on signed ints.
    function automatic t_hsl hsl_of(t_pixel p);
        int r, g, b, mx, mn, d, lt, st, hu;
        t_hsl res;
        r = p.red;
        g = p.green;
        b = p.blue;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        lt = (50 * (mn + mx)) / FS;
        if (mx == mn) begin
            hu = 0;
            st = 0;
        end else begin
            d = mx - mn;
            if (lt < 50) st = (100 * d) / (mx + mn);
            else st = (100 * d) / (2 * FS - mx - mn);
            // blue beats green beats red on ties
            if (b == mx) hu = (240 * d + 60 * (r - g)) / d;
            else if (g == mx) hu = (120 * d + 60 * (b - r)) / d;
            else hu = (60 * (g - b)) / d;
            if (hu < 0) hu += 360;
        end
        res.hue = hu[HUE_W-1:0];
        res.saturation = st[PCT_W-1:0];
        res.lightness = lt[PCT_W-1:0];
        return res;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [CB-1:0] rand_chan();
        return CB'($urandom);
    endfunction

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // Stimulus: directed corners, then random pixels with some forced ties.
    initial begin
        t_pixel p;
        int kind;
        // greys at both ends and mid scale
        pending_pixels.push_back('{8'd0, 8'd0, 8'd0});
        pending_pixels.push_back('{8'hFF, 8'hFF, 8'hFF});
        pending_pixels.push_back('{8'd128, 8'd128, 8'd128});
        // pure primaries and secondaries
        pending_pixels.push_back('{8'hFF, 8'd0, 8'd0});
        pending_pixels.push_back('{8'd0, 8'hFF, 8'd0});
        pending_pixels.push_back('{8'd0, 8'd0, 8'hFF});
        pending_pixels.push_back('{8'hFF, 8'hFF, 8'd0});
        pending_pixels.push_back('{8'd0, 8'hFF, 8'hFF});
        pending_pixels.push_back('{8'hFF, 8'd0, 8'hFF});
        // red sector wrapping negative: blue above green
        pending_pixels.push_back('{8'hFF, 8'd0, 8'd1});
        pending_pixels.push_back('{8'd200, 8'd10, 8'd11});
        pending_pixels.push_back('{8'd255, 8'd0, 8'd254});
        // hue of zero and a small negative fraction truncating to zero
        pending_pixels.push_back('{8'd255, 8'd0, 8'd0});
        pending_pixels.push_back('{8'd254, 8'd1, 8'd2});
        // minimal contrast in dark and bright halves of lightness, then two mixed colours
        pending_pixels.push_back('{8'd1, 8'd0, 8'd0});
        pending_pixels.push_back('{8'd255, 8'd254, 8'd254});
        pending_pixels.push_back('{8'd127, 8'd128, 8'd127});
        pending_pixels.push_back('{8'd128, 8'd127, 8'd128});
        pending_pixels.push_back('{8'hAA, 8'h55, 8'h33});
        pending_pixels.push_back('{8'h55, 8'hAA, 8'hCC});
        for (int i = 0; i < N_RANDOM; i++) begin
            p = '{rand_chan(), rand_chan(), rand_chan()};
            kind = $urandom_range(0, 9);
            case (kind)
                0: p.green = p.red;
                1: p.blue = p.green;
                2: p.blue = p.red;
                3: begin
                    p.green = p.red;
                    p.blue = p.red;
                end
                default: ;
            endcase
            pending_pixels.push_back(p);
        end
        feed_done = 1;
    end

    initial begin
        i_rst_n = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
    end

    // Driver: a transaction holds valid until accepted, then a random gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
            pix_if.data  <= '0;
            send_gap <= 0;
        end else begin
            if (pix_if.valid && pix_if.ready) begin
                expected_hsl.push_back(hsl_of(t_pixel'(pix_if.data)));
            end
            if (pix_if.valid && !pix_if.ready) begin
                // held
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                pix_if.valid <= 1'b0;
            end else if (pending_pixels.size() > 0) begin
                pix_if.data  <= pending_pixels.pop_front();
                pix_if.valid <= 1'b1;
                send_gap <= pick_gap();
            end else begin
                pix_if.valid <= 1'b0;
            end
        end
    end

    // Monitor: compares each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_hsl got, want;
        if (!i_rst_n) begin
            hsl_if.ready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (hsl_if.valid && hsl_if.ready) begin
                got = t_hsl'(hsl_if.data);
                checked++;
                if (expected_hsl.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result h=%0d s=%0d l=%0d",
                                 got.hue, got.saturation, got.lightness);
                end else begin
                    want = expected_hsl.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: exp h=%0d s=%0d l=%0d got h=%0d s=%0d l=%0d",
                                     want.hue, want.saturation, want.lightness,
                                     got.hue, got.saturation, got.lightness);
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                hsl_if.ready <= 1'b0;
            end else begin
                hsl_if.ready <= 1'b1;
                recv_gap <= pick_gap();
            end
        end
    end

    // Watchdog and end of run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_if.valid && pix_if.ready) || (hsl_if.valid && hsl_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        @(posedge i_rst_n);
        while (!(feed_done && pending_pixels.size() == 0 && !pix_if.valid
                 && expected_hsl.size() == 0) && idle_cycles < IDLE_LIMIT)
            @(posedge i_clk);
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: %0d results still expected", expected_hsl.size());
            $display("Simulation FAILED");
        end else begin
            // let any stray output show up past the pipeline depth
            repeat (3 * CB + 10) @(posedge i_clk);
            $display("Covered %0d pixel conversions (greys, ties, hue wrap, all sectors)",
                     checked);
            $display("Mismatches: %0d", mismatches);
            if (mismatches == 0 && expected_hsl.size() == 0)
                $display("Simulation PASSED");
            else
                $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
